[sv/mlfqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfqs_pkg: shared types and constants
// 17.14 fixed-point constants, event kinds and sequencer states for the
// multilevel-feedback priority recalculation block.
// ----------------------------------------------------------------------------
package mlfqs_pkg;

  localparam int FX_SH       = 14;
  localparam int FX_ONE      = 16384;
  localparam int FX_HALF     = 8192;
  localparam int REC_W       = 30;
  localparam int NICE_W      = 6;
  localparam int LOAD_W      = 22;
  localparam int DEC_W       = 14;
  localparam int NICE_LIMIT  = 20;
  localparam int RECENT_LIMIT = 20000 * FX_ONE;
  localparam int LOAD_X100_MAX = 8191;
  localparam int C59         = (59 * FX_ONE) / 60;
  localparam int C1          = FX_ONE / 60;
  localparam int SLICE_TICKS = 4;

  typedef enum logic [1:0] {
    K_TICK   = 2'd0,
    K_NICE   = 2'd1,
    K_CREATE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MOD,
    ST_SMUL,
    ST_SLOAD,
    ST_DINIT,
    ST_DIV,
    ST_SWRD,
    ST_SWMUL,
    ST_SWWR,
    ST_RD2,
    ST_FIN,
    ST_RES
  } state_t;

  function automatic logic signed [REC_W-1:0] clamp_rec(input logic signed [31:0] v);
    logic signed [REC_W-1:0] r;
    if (v > RECENT_LIMIT) begin
      r = REC_W'(RECENT_LIMIT);
    end else if (v < -RECENT_LIMIT) begin
      r = REC_W'(-RECENT_LIMIT);
    end else begin
      r = v[REC_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/mlfqs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfqs_div: load decay coefficient divider
// Restoring divider, one quotient bit per cycle: (2L * 1.0) / (2L + 1.0).
// ----------------------------------------------------------------------------
module mlfqs_div #(
  parameter int NUM_W = 23
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [NUM_W-1:0]              la2,
  output logic                          done,
  output logic [mlfqs_pkg::DEC_W-1:0]   quo
);
  import mlfqs_pkg::*;

  logic [NUM_W:0]   rem;
  logic [NUM_W:0]   den;
  logic [NUM_W+1:0] r2;
  logic [4:0]       cnt;
  logic             busy;

  always_comb begin
    r2 = {rem, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= (NUM_W+1)'(la2);
        den  <= (NUM_W+1)'(la2) + (NUM_W+1)'(FX_ONE);
        cnt  <= 5'(DEC_W);
        quo  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (r2 >= (NUM_W+2)'(den)) begin
          rem <= (NUM_W+1)'(r2 - (NUM_W+2)'(den));
          quo <= {quo[DEC_W-2:0], 1'b1};
        end else begin
          rem <= r2[NUM_W:0];
          quo <= {quo[DEC_W-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/mlfqs_priority_recalc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfqs_priority_recalc: 4.4BSD scheduler priority recalculation
// Per-thread recent CPU (17.14 fixed point), nice and priority, with load
// average decay once per second and priority recompute on nice and create
// beats and every fourth tick that is not idle.
// channel | handshake          | beat contents
// in      | in_valid/in_ready  | kind, thread_slot, running_is_idle,
//         |                    | ready_count, nice_in
// out     | out_valid/out_ready| priority_out, load_avg_x100, recent_cpu_x100
//
// An ordinary beat runs ST_RD, ST_MOD, ST_RD2, ST_FIN, ST_RES. A tick ending a
// second adds ST_SMUL, ST_SLOAD, ST_DINIT and the divider, then a sweep that
// reads, multiplies and writes back one table entry at a time (valid ones only).
// Reset clears load, counters and valid/written bits.
// in_ready is high only while the sequencer is idle; a pending result in
// the output register stalls only the final step of the next beat.
// ----------------------------------------------------------------------------
module mlfqs_priority_recalc #(
  parameter int MAX_THREADS      = 64,
  parameter int TICKS_PER_SECOND = 100,
  parameter int PRIORITY_TOP     = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [5:0]         thread_slot,
  input  logic               running_is_idle,
  input  logic [6:0]         ready_count,
  input  logic signed [5:0]  nice_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         priority_out,
  output logic [12:0]        load_avg_x100,
  output logic signed [21:0] recent_cpu_x100
);
  import mlfqs_pkg::*;

  localparam int IW  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int PW  = (PRIORITY_TOP > 1) ? $clog2(PRIORITY_TOP + 1) : 1;
  localparam int SW  = $clog2(TICKS_PER_SECOND);
  localparam int WW  = PW + NICE_W + REC_W;
  localparam int TOP_FX = PRIORITY_TOP * FX_ONE;

  state_t state, state_next;

  logic [WW-1:0]        mem [MAX_THREADS];
  logic [WW-1:0]        rd_word;
  logic                 ok_q;
  logic [MAX_THREADS-1:0] ok, valid;
  logic [IW-1:0]        rd_idx, wr_idx;
  logic                 wr_en;
  logic [WW-1:0]        wr_word;

  logic [1:0]           kind_q;
  logic [5:0]           slot_q;
  logic                 idle_q;
  logic [7:0]           rdy_q;
  logic signed [NICE_W-1:0] nice_q, nice_clamped;
  logic                 do_sec, do_slice;
  logic [31:0]          tick_cnt, tick_next;
  logic [SW-1:0]        sec_cnt, sec_next;

  logic [LOAD_W-1:0]    load;
  logic [DEC_W-1:0]     dec;
  logic [IW-1:0]        sw_idx;
  logic signed [REC_W-1:0]  mul_a;
  logic [DEC_W-1:0]     mul_b;
  logic signed [REC_W+DEC_W:0] mul_p;

  logic                 div_start, div_done;
  logic [DEC_W-1:0]     div_q;

  logic                 in_range;
  logic [IW-1:0]        slot_idx;
  logic signed [REC_W-1:0]  rd_rec;
  logic signed [NICE_W-1:0] rd_nice;
  logic [PW-1:0]        rd_prio;

  logic signed [REC_W+DEC_W:0] dec_t;
  logic signed [REC_W-1:0]  sw_rec;
  logic signed [REC_W-1:0]  fin_rec;
  logic signed [NICE_W-1:0] fin_nice;
  logic [PW-1:0]        fin_prio, new_prio;
  logic                 recompute;
  logic signed [REC_W-1:0]  q4;
  logic signed [31:0]   pv, pr;

  logic signed [REC_W-1:0]  cur_rec;
  logic [PW-1:0]        cur_prio;
  logic                 cur_in;
  logic [31:0]          lx;
  logic [REC_W-1:0]     rmag;
  logic [REC_W+7:0]     rx;

  assign in_ready  = (state == ST_IDLE);
  assign in_range  = (32'(slot_q) < MAX_THREADS);
  assign slot_idx  = IW'(slot_q);
  assign tick_next = tick_cnt + 32'd1;

  always_comb begin
    if (tick_next == 32'd0 || 32'(sec_cnt) == TICKS_PER_SECOND - 1) begin
      sec_next = '0;
    end else begin
      sec_next = sec_cnt + SW'(1);
    end
    if (nice_in > NICE_W'(NICE_LIMIT)) begin
      nice_clamped = NICE_W'(NICE_LIMIT);
    end else if (nice_in < -NICE_W'(NICE_LIMIT)) begin
      nice_clamped = -NICE_W'(NICE_LIMIT);
    end else begin
      nice_clamped = nice_in;
    end
  end

  assign rd_rec  = ok_q ? $signed(rd_word[REC_W-1:0]) : '0;
  assign rd_nice = ok_q ? $signed(rd_word[REC_W +: NICE_W]) : '0;
  assign rd_prio = rd_word[REC_W+NICE_W +: PW];

  always_comb begin
    if (state == ST_SMUL) begin
      mul_a = REC_W'(load);
      mul_b = DEC_W'(C59);
    end else begin
      mul_a = rd_rec;
      mul_b = dec;
    end
  end

  always_comb begin
    if (mul_p < 0) begin
      dec_t = (mul_p + (REC_W+DEC_W+1)'(FX_ONE - 1)) >>> FX_SH;
    end else begin
      dec_t = mul_p >>> FX_SH;
    end
    sw_rec = clamp_rec(32'($signed(dec_t[REC_W-1:0])) + (32'(rd_nice) <<< FX_SH));
  end

  always_comb begin
    fin_nice = (kind_q == K_NICE || kind_q == K_CREATE) ? nice_q : rd_nice;
    fin_rec  = (kind_q == K_CREATE) ? '0 : rd_rec;
    recompute = (kind_q == K_NICE) || (kind_q == K_CREATE) ||
                (kind_q == K_TICK && do_slice && !idle_q);
    if (fin_rec < 0) begin
      q4 = (fin_rec + REC_W'(3)) >>> 2;
    end else begin
      q4 = fin_rec >>> 2;
    end
    pv = 32'(TOP_FX) - 32'(q4) - (32'(fin_nice) <<< (FX_SH + 1));
    pr = (pv + 32'(FX_HALF)) >>> FX_SH;
    if (pv < 0) begin
      new_prio = '0;
    end else if (pr > PRIORITY_TOP) begin
      new_prio = PW'(PRIORITY_TOP);
    end else begin
      new_prio = PW'(pr);
    end
    fin_prio = recompute ? new_prio : rd_prio;
  end

  always_comb begin
    state_next = state;
    rd_idx     = slot_idx;
    wr_idx     = slot_idx;
    wr_en      = 1'b0;
    wr_word    = {rd_prio, rd_nice, rd_rec};
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RD;
        end
      end
      ST_RD: state_next = ST_MOD;
      ST_MOD: begin
        if (kind_q == K_TICK && !idle_q && in_range) begin
          wr_en   = 1'b1;
          wr_word = {rd_prio, rd_nice, clamp_rec(32'(rd_rec) + 32'(FX_ONE))};
        end
        state_next = do_sec ? ST_SMUL : ST_RD2;
      end
      ST_SMUL:  state_next = ST_SLOAD;
      ST_SLOAD: state_next = ST_DINIT;
      ST_DINIT: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SWRD;
        end
      end
      ST_SWRD: begin
        rd_idx     = sw_idx;
        state_next = ST_SWMUL;
      end
      ST_SWMUL: begin
        rd_idx     = sw_idx;
        state_next = ST_SWWR;
      end
      ST_SWWR: begin
        rd_idx  = sw_idx;
        wr_idx  = sw_idx;
        wr_en   = valid[sw_idx];
        wr_word = {rd_prio, rd_nice, sw_rec};
        state_next = (sw_idx == IW'(MAX_THREADS - 1)) ? ST_RD2 : ST_SWRD;
      end
      ST_RD2: state_next = ST_FIN;
      ST_FIN: begin
        wr_en      = in_range;
        wr_word    = {fin_prio, fin_nice, fin_rec};
        state_next = ST_RES;
      end
      ST_RES: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_word;
    end
    rd_word <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ok    <= '0;
      valid <= '0;
      ok_q  <= 1'b0;
    end else begin
      ok_q <= ok[rd_idx];
      if (wr_en) begin
        ok[wr_idx] <= 1'b1;
      end
      if (state == ST_FIN && in_range && kind_q == K_CREATE) begin
        valid[slot_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * $signed({1'b0, mul_b});
  end

  mlfqs_div #(.NUM_W(LOAD_W + 1)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .la2   ({load, 1'b0}),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      load     <= '0;
      tick_cnt <= '0;
      sec_cnt  <= '0;
      do_sec   <= 1'b0;
      do_slice <= 1'b0;
    end else begin
      if (state == ST_IDLE && in_valid) begin
        if (kind == K_TICK) begin
          tick_cnt <= tick_next;
          sec_cnt  <= sec_next;
          do_sec   <= (sec_next == '0);
          do_slice <= ((tick_next % SLICE_TICKS) == 32'd0);
        end else begin
          do_sec   <= 1'b0;
          do_slice <= 1'b0;
        end
      end
      if (state == ST_SLOAD) begin
        load <= LOAD_W'(mul_p >>> FX_SH) + LOAD_W'(rdy_q * 16'(C1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      kind_q <= kind;
      slot_q <= thread_slot;
      idle_q <= running_is_idle;
      rdy_q  <= 8'(ready_count) + 8'(!running_is_idle);
      nice_q <= nice_clamped;
    end
    if (state == ST_DINIT) begin
      sw_idx <= '0;
    end else if (state == ST_SWWR) begin
      sw_idx <= sw_idx + IW'(1);
    end
    if (state == ST_DIV && div_done) begin
      dec <= div_q;
    end
    if (state == ST_FIN) begin
      cur_in   <= in_range;
      cur_rec  <= in_range ? fin_rec : '0;
      cur_prio <= in_range ? fin_prio : '0;
    end
  end

  always_comb begin
    lx   = (32'(load) * 32'd100 + 32'(FX_HALF)) >> FX_SH;
    rmag = (cur_rec < 0) ? REC_W'(-cur_rec) : REC_W'(cur_rec);
    rx   = ((REC_W+8)'(rmag) * (REC_W+8)'(100) + (REC_W+8)'(FX_HALF)) >> FX_SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RES && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RES && (!out_valid || out_ready)) begin
      priority_out    <= cur_in ? 6'(cur_prio) : 6'd0;
      load_avg_x100   <= (lx > LOAD_X100_MAX) ? 13'(LOAD_X100_MAX) : 13'(lx);
      recent_cpu_x100 <= (cur_rec < 0) ? -$signed(22'(rx)) : $signed(22'(rx));
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_RD)
    else $error("accepted beat did not start a table read");

  a_sweep_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWRD || state == ST_SWWR) |-> 32'(sw_idx) < MAX_THREADS)
    else $error("sweep index beyond table");

  a_div_to_sweep: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && div_done |=> state == ST_SWRD)
    else $error("divider done without starting the sweep");

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load < LOAD_W'(1 << 21))
    else $error("load average out of range");

  a_rec_clamp: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ($signed(wr_word[REC_W-1:0]) <= RECENT_LIMIT &&
               $signed(wr_word[REC_W-1:0]) >= -RECENT_LIMIT))
    else $error("recent cpu written beyond clamp");

endmodule
